/* rtl/tsq_pkg.sv */
// Shared types and constants for the tone sequencer.
// Holds field widths, command and register codes, the sequencer state type
// and the note entry layout. No dependencies.
`timescale 1ns / 1ps

package tsq_pkg;

  localparam int MUSIC_DEPTH_DEF  = 256;
  localparam int EFFECT_DEPTH_DEF = 64;

  localparam int CMD_W      = 3;
  localparam int IDX_W      = 8;
  localparam int PITCH_W    = 16;
  localparam int DUR_W      = 16;
  localparam int RELOAD_W   = 24;
  localparam int CLK_W      = 17;
  localparam int LEN_W      = 9;
  localparam int TICKS_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int HZ_W       = 27;   // clock in hertz, clock_khz * 1000
  localparam int DIVIDEND_W = 33;   // duration * clock_khz

  localparam logic [RELOAD_W-1:0] REST_RELOAD   = RELOAD_W'(16000);
  localparam logic [RELOAD_W-1:0] RELOAD_MAX    = '1;
  localparam logic [TICKS_W-1:0]  TICKS_MAX     = '1;
  localparam logic [9:0]          KHZ_TO_HZ     = 10'd1000;
  localparam logic [CLK_W-1:0]    CLOCK_KHZ_RST = CLK_W'(16000);
  localparam logic [LEN_W-1:0]    MUSIC_LEN_RST = LEN_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 3'd0,
    CMD_WRITE_MUSIC = 3'd1,
    CMD_WRITE_SFX   = 3'd2,
    CMD_RESTART_MUS = 3'd3,
    CMD_START_SFX   = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MUSIC_LENGTH = 1'b0,
    CFG_CLOCK_KHZ    = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SELECT,
    ST_DIV_RELOAD,
    ST_START_COUNT,
    ST_DIV_COUNT,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic [DUR_W-1:0]   dur;
  } note_t;

endpackage

/* rtl/tone_sequencer_with_sfx_priority.sv */
// Square-wave tone sequencer with sound-effect priority: top level.
// Depends on tsq_pkg, tsq_table and tsq_divider.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one command item: a tick,
//   a table write, a music restart or an effect start. Every accepted item
//   yields exactly one result item on the output channel (out_valid_o /
//   out_ready_i): speaker level, timer reload, note-started flag and the
//   effect flag.
//   Config channel (cfg_valid_i / cfg_ready_o) writes music_length (index 0)
//   or clock_khz (index 1); it is always ready. Write it only while idle.
//   Flow: writes, restarts, unused codes and ticks with time left load the
//   result at the accepting edge, one item a cycle back to back while the
//   output is free. A fetching tick runs the shared divider twice (33 quotient
//   steps each), or once for a rest, and loads its result after the last one.
//   Reset: both note tables are swept to zero, one entry a cycle, over
//   max(MUSIC_DEPTH, EFFECT_DEPTH) entries; the input channel is not ready
//   during the sweep. Config writes are taken throughout.
//   Stall: a single output register holds the result; a new item is taken
//   only when that register is empty or being emptied in the same cycle.
`timescale 1ns / 1ps

module tone_sequencer_with_sfx_priority #(
  parameter int MUSIC_DEPTH  = tsq_pkg::MUSIC_DEPTH_DEF,
  parameter int EFFECT_DEPTH = tsq_pkg::EFFECT_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command items
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tsq_pkg::CMD_W-1:0]        command_i,
  input  logic [tsq_pkg::IDX_W-1:0]        entry_index_i,
  input  logic [tsq_pkg::PITCH_W-1:0]      note_pitch_i,
  input  logic [tsq_pkg::DUR_W-1:0]        note_duration_ms_i,
  // result items
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             speaker_level_o,
  output logic [tsq_pkg::RELOAD_W-1:0]     timer_reload_o,
  output logic                             note_started_o,
  output logic                             playing_effect_o,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tsq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [tsq_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import tsq_pkg::*;

  localparam int MAW       = $clog2(MUSIC_DEPTH);        // music address
  localparam int EAW       = $clog2(EFFECT_DEPTH);       // effect address
  localparam int EPW       = $clog2(EFFECT_DEPTH + 1);   // effect position, can hit depth
  localparam int MLW       = MAW + 1;                    // effective music length
  localparam int CLR_DEPTH = (MUSIC_DEPTH > EFFECT_DEPTH) ? MUSIC_DEPTH : EFFECT_DEPTH;
  localparam int CLW       = $clog2(CLR_DEPTH);
  localparam int NOTE_W    = $bits(note_t);

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  seq_state_e            state_q, state_d;
  logic [CLW-1:0]        clr_q;
  logic [LEN_W-1:0]      music_length_q;
  logic [CLK_W-1:0]      clock_khz_q;
  logic [MAW-1:0]        music_pos_q;
  logic [EPW-1:0]        effect_pos_q;
  logic [TICKS_W-1:0]    ticks_left_q;
  logic                  held_tone_q;      // held pitch is nonzero
  logic                  speaker_q;
  logic [RELOAD_W-1:0]   reload_q;
  logic                  effect_flag_q;
  logic [DUR_W-1:0]      dur_q;            // duration of the note being fetched

  // output register
  logic                  out_valid_q;
  logic                  out_speaker_q;
  logic [RELOAD_W-1:0]   out_reload_q;
  logic                  out_started_q;
  logic                  out_effect_q;

  // ---------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------
  logic                  out_free;
  logic                  in_accept;
  logic                  is_tick, is_wr_music, is_wr_sfx, is_restart, is_sfx_start;
  logic                  fetch_now;
  logic                  music_idx_ok, sfx_idx_ok;

  note_t                 music_rd, effect_rd, sel_note;
  logic                  sfx_live;
  logic [MLW-1:0]        music_len_eff;
  logic [MLW-1:0]        music_pos_inc;

  logic                  mus_we, sfx_we;
  logic [MAW-1:0]        mus_waddr;
  logic [EAW-1:0]        sfx_waddr;
  note_t                 wr_note;

  logic                  div_start;
  logic [DIVIDEND_W-1:0] div_dividend;
  logic [RELOAD_W-1:0]   div_divisor;
  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quot;
  logic [HZ_W-1:0]       clock_hz;
  logic [DIVIDEND_W-1:0] dur_clk;
  logic [RELOAD_W-1:0]   reload_clamped;
  logic [TICKS_W-1:0]    count_sat;

  logic                  out_load;
  logic                  out_speaker_d;
  logic                  out_started_d;

  assign out_free  = !out_valid_q || out_ready_i;

  assign is_tick      = command_i == CMD_TICK;
  assign is_wr_music  = command_i == CMD_WRITE_MUSIC;
  assign is_wr_sfx    = command_i == CMD_WRITE_SFX;
  assign is_restart   = command_i == CMD_RESTART_MUS;
  assign is_sfx_start = command_i == CMD_START_SFX;

  assign music_idx_ok = 32'(entry_index_i) < MUSIC_DEPTH;
  assign sfx_idx_ok   = 32'(entry_index_i) < EFFECT_DEPTH;

  assign fetch_now = in_accept && is_tick && (ticks_left_q == '0);

  // clamp the programmed length into 1..MUSIC_DEPTH
  always_comb begin
    if (music_length_q == '0) begin
      music_len_eff = MLW'(1);
    end else if (32'(music_length_q) > MUSIC_DEPTH) begin
      music_len_eff = MLW'(MUSIC_DEPTH);
    end else begin
      music_len_eff = MLW'(music_length_q);
    end
  end

  assign music_pos_inc = {1'b0, music_pos_q} + MLW'(1);

  // effect entry wins unless it is the all-zero terminator or past the end
  assign sfx_live = (32'(effect_pos_q) < EFFECT_DEPTH) && (effect_rd != '0);
  assign sel_note = sfx_live ? effect_rd : music_rd;

  assign clock_hz = HZ_W'(clock_khz_q) * HZ_W'(KHZ_TO_HZ);
  assign dur_clk  = DIVIDEND_W'(dur_q) * DIVIDEND_W'(clock_khz_q);

  // reload: quotient clamped to 1..RELOAD_MAX
  always_comb begin
    if (div_quot == '0) begin
      reload_clamped = RELOAD_W'(1);
    end else if (|div_quot[DIVIDEND_W-1:RELOAD_W]) begin
      reload_clamped = RELOAD_MAX;
    end else begin
      reload_clamped = div_quot[RELOAD_W-1:0];
    end
  end

  assign count_sat = div_quot[DIVIDEND_W-1] ? TICKS_MAX : div_quot[TICKS_W-1:0];

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CLW'(CLR_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (fetch_now) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_SELECT;
      end
      ST_SELECT: begin
        state_d = (sel_note.pitch == '0) ? ST_START_COUNT : ST_DIV_RELOAD;
      end
      ST_DIV_RELOAD: begin
        if (div_done) begin
          state_d = ST_START_COUNT;
        end
      end
      ST_START_COUNT: begin
        state_d = ST_DIV_COUNT;
      end
      ST_DIV_COUNT: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: control outputs
  // ---------------------------------------------------------------------
  always_comb begin
    in_ready_o    = 1'b0;
    mus_we        = 1'b0;
    sfx_we        = 1'b0;
    mus_waddr     = MAW'(entry_index_i);
    sfx_waddr     = EAW'(entry_index_i);
    wr_note.pitch = note_pitch_i;
    wr_note.dur   = note_duration_ms_i;
    div_start     = 1'b0;
    div_dividend  = DIVIDEND_W'(clock_hz);
    div_divisor   = RELOAD_W'({sel_note.pitch, 1'b0});
    out_load      = 1'b0;
    out_speaker_d = speaker_q;
    out_started_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        // sweep both tables to zero
        mus_we    = 1'b1;
        sfx_we    = 32'(clr_q) < EFFECT_DEPTH;
        mus_waddr = MAW'(clr_q);
        sfx_waddr = EAW'(clr_q);
        wr_note   = '0;
      end
      ST_IDLE: begin
        in_ready_o = out_free;
        mus_we     = in_accept && is_wr_music && music_idx_ok;
        sfx_we     = in_accept && is_wr_sfx && sfx_idx_ok;
        // everything but a fetching tick answers right away
        out_load   = in_accept && !fetch_now;
        if (is_tick && held_tone_q) begin
          out_speaker_d = !speaker_q;
        end
      end
      ST_SELECT: begin
        div_start = sel_note.pitch != '0;
      end
      ST_START_COUNT: begin
        div_start    = 1'b1;
        div_dividend = dur_clk;
        div_divisor  = reload_q;
      end
      ST_DONE: begin
        out_load      = out_free;
        out_started_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------
  // Tables and shared divider
  // ---------------------------------------------------------------------
  tsq_table #(
    .DEPTH (MUSIC_DEPTH),
    .WIDTH (NOTE_W)
  ) u_music_table (
    .clk_i   (clk_i),
    .we_i    (mus_we),
    .waddr_i (mus_waddr),
    .wdata_i (wr_note),
    .raddr_i (music_pos_q),
    .rdata_o (music_rd)
  );

  tsq_table #(
    .DEPTH (EFFECT_DEPTH),
    .WIDTH (NOTE_W)
  ) u_effect_table (
    .clk_i   (clk_i),
    .we_i    (sfx_we),
    .waddr_i (sfx_waddr),
    .wdata_i (wr_note),
    .raddr_i (effect_pos_q[EAW-1:0]),
    .rdata_o (effect_rd)
  );

  tsq_divider #(
    .DW (DIVIDEND_W),
    .VW (RELOAD_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_CLEAR;
      clr_q          <= '0;
      music_length_q <= MUSIC_LEN_RST;
      clock_khz_q    <= CLOCK_KHZ_RST;
      music_pos_q    <= '0;
      effect_pos_q   <= '0;
      ticks_left_q   <= '0;
      held_tone_q    <= 1'b0;
      speaker_q      <= 1'b0;
      reload_q       <= REST_RELOAD;
      effect_flag_q  <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;

      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + CLW'(1);
      end

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_MUSIC_LENGTH: music_length_q <= cfg_data_i[LEN_W-1:0];
          CFG_CLOCK_KHZ:    clock_khz_q    <= cfg_data_i[CLK_W-1:0];
          default: begin
          end
        endcase
      end

      // commands that finish when accepted
      if (in_accept) begin
        if (is_restart) begin
          music_pos_q <= '0;
        end
        if (is_sfx_start) begin
          effect_pos_q <= '0;
        end
        if (is_tick && (ticks_left_q != '0)) begin
          ticks_left_q <= ticks_left_q - TICKS_W'(1);
          speaker_q    <= out_speaker_d;
        end
      end

      // note fetch: advance the winning table's position
      if (state_q == ST_SELECT) begin
        effect_flag_q <= sfx_live;
        held_tone_q   <= sel_note.pitch != '0;
        if (sfx_live) begin
          effect_pos_q <= effect_pos_q + EPW'(1);
        end else begin
          music_pos_q <= (music_pos_inc >= music_len_eff) ? '0 : music_pos_inc[MAW-1:0];
        end
        if (sel_note.pitch == '0) begin
          reload_q <= REST_RELOAD;
        end
      end

      if ((state_q == ST_DIV_RELOAD) && div_done) begin
        reload_q <= reload_clamped;
      end

      if ((state_q == ST_DIV_COUNT) && div_done) begin
        ticks_left_q <= count_sat;
      end

      // hold the result until taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SELECT) begin
      dur_q <= sel_note.dur;
    end
    if (out_load) begin
      out_speaker_q <= out_speaker_d;
      out_reload_q  <= reload_q;
      out_started_q <= out_started_d;
      out_effect_q  <= effect_flag_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign speaker_level_o  = out_speaker_q;
  assign timer_reload_o   = out_reload_q;
  assign note_started_o   = out_started_q;
  assign playing_effect_o = out_effect_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(out_reload_q))
    else $error("pending result overwritten");

  a_reload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reload_q != '0)
    else $error("timer reload reached zero");

  a_effect_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(effect_pos_q) <= EFFECT_DEPTH)
    else $error("effect position past table end");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o)
    else $error("item taken while sequencer busy");

  a_fetch_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> out_valid_q && out_started_q)
    else $error("fetch result not flagged as note start");

endmodule

/* rtl/tsq_table.sv */
// Note table memory: one write port, one registered read port.
// Depends on nothing; widths come from parameters.
`timescale 1ns / 1ps

module tsq_table #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tsq_divider.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing; the divisor must be nonzero when started.
`timescale 1ns / 1ps

module tsq_divider #(
  parameter int DW = 33,
  parameter int VW = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] div_q, div_d;
  logic [VW:0]   rem_shift;
  logic [VW:0]   rem_diff;
  logic          fits;

  // one restoring step: bring in the next dividend bit, subtract if it fits
  assign rem_shift = {rem_q, quo_q[DW-1]};
  assign rem_diff  = rem_shift - {1'b0, div_q};
  assign fits      = rem_shift >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[DW-2:0], fits};
      rem_d = fits ? rem_diff[VW-1:0] : rem_shift[VW-1:0];
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* bench/tsq_checker.sv */
// Scoreboard for the tone sequencer: watches the command, result and register
// channels, predicts every result item and compares it field by field.
// Depends on tsq_pkg.
`timescale 1ns / 1ps

module tsq_checker #(
  parameter int MUSIC_DEPTH  = tsq_pkg::MUSIC_DEPTH_DEF,
  parameter int EFFECT_DEPTH = tsq_pkg::EFFECT_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  logic [tsq_pkg::CMD_W-1:0]      command_i,
  input  logic [tsq_pkg::IDX_W-1:0]      entry_index_i,
  input  logic [tsq_pkg::PITCH_W-1:0]    note_pitch_i,
  input  logic [tsq_pkg::DUR_W-1:0]      note_duration_ms_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  logic                           speaker_level_i,
  input  logic [tsq_pkg::RELOAD_W-1:0]   timer_reload_i,
  input  logic                           note_started_i,
  input  logic                           playing_effect_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [tsq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tsq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    mismatch_count_o,
  output int unsigned                    pending_o
);

  import tsq_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic                speaker;
    logic [RELOAD_W-1:0] reload;
    logic                started;
    logic                sfx;
  } tone_out_t;

  logic [PITCH_W-1:0] tune_pitch [MUSIC_DEPTH];
  logic [DUR_W-1:0]   tune_dur   [MUSIC_DEPTH];
  logic [PITCH_W-1:0] sfx_pitch  [EFFECT_DEPTH];
  logic [DUR_W-1:0]   sfx_dur    [EFFECT_DEPTH];
  int unsigned        tune_pos;
  int unsigned        sfx_pos;
  logic [TICKS_W-1:0] ticks_left;
  logic [PITCH_W-1:0] pitch_held;
  logic               speaker;
  logic [RELOAD_W-1:0] reload;
  logic               from_sfx;
  logic [LEN_W-1:0]   tune_len;
  logic [CLK_W-1:0]   clock_khz;

  tone_out_t   tone_expect_q [$];
  int unsigned fails;
  int unsigned results_seen;

  // Apply one command item to the player state and return the result it shows.
  function automatic tone_out_t advance_player(input logic [CMD_W-1:0]   cmd,
                                               input logic [IDX_W-1:0]   idx,
                                               input logic [PITCH_W-1:0] pitch,
                                               input logic [DUR_W-1:0]   dur);
    tone_out_t          r;
    logic               started;
    logic               take_sfx;
    logic [PITCH_W-1:0] np;
    logic [DUR_W-1:0]   nd;
    int unsigned        span;
    longint unsigned    period;
    longint unsigned    count;
    started = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (ticks_left == '0) begin
          started  = 1'b1;
          take_sfx = 1'b0;
          if (sfx_pos < EFFECT_DEPTH) begin
            take_sfx = (sfx_pitch[sfx_pos] != '0) || (sfx_dur[sfx_pos] != '0);
          end
          if (take_sfx) begin
            np      = sfx_pitch[sfx_pos];
            nd      = sfx_dur[sfx_pos];
            sfx_pos = sfx_pos + 1;
          end else begin
            span = tune_len;
            if (span == 0) span = 1;
            if (span > MUSIC_DEPTH) span = MUSIC_DEPTH;
            if (tune_pos >= MUSIC_DEPTH) tune_pos = 0;
            np       = tune_pitch[tune_pos];
            nd       = tune_dur[tune_pos];
            tune_pos = (tune_pos + 1 >= span) ? 0 : tune_pos + 1;
          end
          from_sfx   = take_sfx;
          pitch_held = np;
          if (np == '0) begin
            period = REST_RELOAD;
          end else begin
            period = (64'(clock_khz) * 64'(KHZ_TO_HZ)) / (64'd2 * 64'(np));
          end
          if (period < 1) period = 1;
          if (period > RELOAD_MAX) period = RELOAD_MAX;
          reload     = RELOAD_W'(period);
          count      = (64'(nd) * 64'(clock_khz)) / period;
          ticks_left = (count > TICKS_MAX) ? TICKS_MAX : TICKS_W'(count);
        end else begin
          ticks_left = ticks_left - 1'b1;
          if (pitch_held != '0) speaker = ~speaker;
        end
      end
      CMD_WRITE_MUSIC: begin
        if (idx < MUSIC_DEPTH) begin
          tune_pitch[idx] = pitch;
          tune_dur[idx]   = dur;
        end
      end
      CMD_WRITE_SFX: begin
        if (idx < EFFECT_DEPTH) begin
          sfx_pitch[idx] = pitch;
          sfx_dur[idx]   = dur;
        end
      end
      CMD_RESTART_MUS: tune_pos = 0;
      CMD_START_SFX:   sfx_pos = 0;
      default: ;
    endcase
    r.speaker = speaker;
    r.reload  = reload;
    r.started = started;
    r.sfx     = from_sfx;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tone_out_t seen;
    tone_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MUSIC_DEPTH; i++) begin
        tune_pitch[i] = '0;
        tune_dur[i]   = '0;
      end
      for (int i = 0; i < EFFECT_DEPTH; i++) begin
        sfx_pitch[i] = '0;
        sfx_dur[i]   = '0;
      end
      tune_pos     = 0;
      sfx_pos      = 0;
      ticks_left   = '0;
      pitch_held   = '0;
      speaker      = 1'b0;
      reload       = REST_RELOAD;
      from_sfx     = 1'b0;
      tune_len     = MUSIC_LEN_RST;
      clock_khz    = CLOCK_KHZ_RST;
      fails        = 0;
      results_seen = 0;
      tone_expect_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_MUSIC_LENGTH: tune_len  = cfg_data_i[LEN_W-1:0];
          CFG_CLOCK_KHZ:    clock_khz = cfg_data_i[CLK_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        seen = '{speaker_level_i, timer_reload_i, note_started_i, playing_effect_i};
        results_seen++;
        if (tone_expect_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_LIMIT) begin
            $display("%0t: tone item %0d arrived with nothing pending", $realtime,
                     results_seen);
          end
        end else begin
          want = tone_expect_q.pop_front();
          if (seen.speaker !== want.speaker || seen.reload !== want.reload ||
              seen.started !== want.started || seen.sfx !== want.sfx) begin
            fails++;
            if (fails <= REPORT_LIMIT) begin
              $display("%0t: tone item %0d mismatch: exp spk=%0b reload=%0d start=%0b fx=%0b",
                       $realtime, results_seen, want.speaker, want.reload, want.started,
                       want.sfx);
              $display("    got spk=%0b reload=%0d start=%0b fx=%0b", seen.speaker,
                       seen.reload, seen.started, seen.sfx);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        tone_expect_q.push_back(advance_player(command_i, entry_index_i, note_pitch_i,
                                               note_duration_ms_i));
      end
    end
    pending_o        <= tone_expect_q.size();
    mismatch_count_o <= fails;
  end

endmodule

/* bench/tb.sv */
// Testbench top for the tone sequencer: clock, reset, command and register
// stimulus, random back-pressure, watchdog and verdict.
// Depends on tsq_pkg, tsq_checker and the tone_sequencer_with_sfx_priority RTL.
`timescale 1ns / 1ps

module tb;

  import tsq_pkg::*;

  localparam int STALL_LIMIT   = 2000;  // cycles without any handshake before giving up
  localparam int ITEM_GOAL     = 650;
  localparam int PHASE_ITEMS   = 100;
  localparam int CALM_TAIL     = 80;    // last items run with no idling at all
  localparam int SETTLE_CYCLES = 100;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  logic                  clk_i              = 1'b0;
  logic                  rst_ni             = 1'b0;
  logic                  in_valid_i         = 1'b0;
  logic                  in_ready_o;
  logic [CMD_W-1:0]      command_i          = '0;
  logic [IDX_W-1:0]      entry_index_i      = '0;
  logic [PITCH_W-1:0]    note_pitch_i       = '0;
  logic [DUR_W-1:0]      note_duration_ms_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i        = 1'b0;
  logic                  speaker_level_o;
  logic [RELOAD_W-1:0]   timer_reload_o;
  logic                  note_started_o;
  logic                  playing_effect_o;
  logic                  cfg_valid_i        = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i        = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i         = '0;

  int unsigned mismatches;
  int unsigned awaiting;
  bit          calm        = 1'b0;  // no idling on either side while set
  int unsigned items_sent  = 0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned tune_span   = 1;     // music entries in play, steers write indexes

  always begin
    #2;
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
  end

  tone_sequencer_with_sfx_priority i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .entry_index_i,
    .note_pitch_i,
    .note_duration_ms_i,
    .out_valid_o,
    .out_ready_i,
    .speaker_level_o,
    .timer_reload_o,
    .note_started_o,
    .playing_effect_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  tsq_checker i_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i         (in_ready_o),
    .command_i,
    .entry_index_i,
    .note_pitch_i,
    .note_duration_ms_i,
    .out_valid_i        (out_valid_o),
    .out_ready_i,
    .speaker_level_i    (speaker_level_o),
    .timer_reload_i     (timer_reload_o),
    .note_started_i     (note_started_o),
    .playing_effect_i   (playing_effect_o),
    .cfg_valid_i,
    .cfg_ready_i        (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .mismatch_count_o   (mismatches),
    .pending_o          (awaiting)
  );

  // Result side: hold ready low for random bursts, unless running calm.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(1, 9) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Pick a note whose tick count stays short at any clock setting, so that
  // fetches keep coming: roughly duration * 2 * pitch / 1000 ticks, or
  // duration * clock_khz / 16000 for a rest.
  function automatic void pick_note(output logic [PITCH_W-1:0] p,
                                    output logic [DUR_W-1:0]   d);
    case ($urandom_range(0, 3))
      0: begin
        p = '0;
        d = DUR_W'($urandom_range(0, 4));
      end
      1: begin
        p = PITCH_W'($urandom_range(1, 65535));
        d = DUR_W'($urandom_range(0, 6000 / p));
      end
      default: begin
        p = PITCH_W'($urandom_range(20, 2000));
        d = DUR_W'($urandom_range(0, 6000 / p));
      end
    endcase
  endfunction

  // Offer one command item and hold it until accepted. Valid is left high on
  // return so that a back-to-back item never lowers and raises it in one step.
  task automatic put_item(input logic [CMD_W-1:0]   cmd,
                          input logic [IDX_W-1:0]   idx,
                          input logic [PITCH_W-1:0] p,
                          input logic [DUR_W-1:0]   d,
                          input bit                 counts);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i         <= 1'b1;
    command_i          <= cmd;
    entry_index_i      <= idx;
    note_pitch_i       <= p;
    note_duration_ms_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    if (counts) items_sent++;
  endtask

  task automatic write_reg(input cfg_reg_e which, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= which;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Drain every pending result, then write both registers.
  task automatic set_phase(input logic [CFG_DATA_W-1:0] len_word,
                           input logic [CFG_DATA_W-1:0] khz);
    in_valid_i <= 1'b0;
    while (awaiting != 0) @(negedge clk_i);
    write_reg(CFG_MUSIC_LENGTH, len_word);
    write_reg(CFG_CLOCK_KHZ, khz);
    cfg_valid_i <= 1'b0;
    tune_span = 32'(len_word[LEN_W-1:0]);
    if (tune_span == 0) tune_span = 1;
    if (tune_span > MUSIC_DEPTH_DEF) tune_span = MUSIC_DEPTH_DEF;
  endtask

  initial begin
    logic [PITCH_W-1:0] p;
    logic [DUR_W-1:0]   d;
    int unsigned        pick;
    int unsigned        n;
    int unsigned        phase;
    int unsigned        next_phase_at;
    bit                 sweep_done;

    phase      = 0;
    sweep_done = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero clock and a zero length first. With no clock every tone
    // fetch gets reload 1 and every fetch zero ticks, so the widest durations are safe.
    set_phase('0, '0);
    put_item(CMD_TICK, '0, '0, '0, 1'b1);               // empty table: a rest
    put_item(CMD_WRITE_MUSIC, '0, '1, '1, 1'b1);
    put_item(CMD_TICK, '1, '1, '1, 1'b1);               // reload clamps to 1
    put_item(CMD_TICK, '0, '0, '0, 1'b1);               // length 0 loops one entry
    put_item(CMD_WRITE_MUSIC, '0, '0, '1, 1'b1);
    put_item(CMD_TICK, '0, '0, '0, 1'b1);               // long rest, still zero ticks
    // Replace the wide entries before any clock comes back.
    put_item(CMD_WRITE_MUSIC, '0, PITCH_W'(1), DUR_W'(2000), 1'b1);
    put_item(CMD_WRITE_MUSIC, '1, PITCH_W'(16'h8000), '0, 1'b1);
    put_item(CMD_WRITE_SFX, IDX_W'(EFFECT_DEPTH_DEF - 1), PITCH_W'(100), '0, 1'b1);
    // Writes past the effect table are dropped.
    put_item(CMD_WRITE_SFX, IDX_W'(EFFECT_DEPTH_DEF), '1, '1, 1'b0);
    put_item(CMD_WRITE_SFX, '1, PITCH_W'(16'hAAAA), DUR_W'(16'h5555), 1'b0);
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++) begin
      put_item(CMD_W'(c), IDX_W'($urandom), PITCH_W'($urandom), DUR_W'($urandom), 1'b0);
    end
    put_item(CMD_WRITE_SFX, '0, PITCH_W'(440), DUR_W'(3), 1'b1);
    put_item(CMD_WRITE_SFX, IDX_W'(1), '0, '0, 1'b1);   // terminator
    put_item(CMD_START_SFX, '0, '0, '0, 1'b1);
    put_item(CMD_TICK, '0, '0, '0, 1'b1);               // effect wins
    put_item(CMD_TICK, '0, '0, '0, 1'b1);               // terminator: back to music
    put_item(CMD_RESTART_MUS, '0, '0, '0, 1'b1);
    // Widest clock: pitch 1 saturates the reload at the top.
    set_phase(CFG_DATA_W'(2), '1);
    put_item(CMD_WRITE_MUSIC, IDX_W'(1), '1, '0, 1'b1);
    put_item(CMD_TICK, '0, '0, '0, 1'b1);
    put_item(CMD_TICK, '0, '0, '0, 1'b1);

    // Random part: phases of different settings, drained between them.
    next_phase_at = items_sent;
    while (items_sent < ITEM_GOAL) begin
      if (items_sent >= next_phase_at) begin
        case (phase % 6)
          0: set_phase(CFG_DATA_W'(4), CLK_W'(16000));
          1: set_phase(CFG_DATA_W'(511), CLK_W'(100000));    // above depth: full table
          2: set_phase(CFG_DATA_W'(1), CLK_W'(1000));
          3: set_phase(CFG_DATA_W'(256), CLK_W'($urandom_range(1000, 100000)));
          4: set_phase(CFG_DATA_W'(17'h1FE03), '1);          // bits above the length field drop
          default: set_phase(CFG_DATA_W'($urandom_range(1, 32)),
                             CLK_W'($urandom_range(1000, 100000)));
        endcase
        phase++;
        next_phase_at += PHASE_ITEMS;
        calm = ($urandom_range(0, 3) == 0);
      end
      if (items_sent + CALM_TAIL >= ITEM_GOAL) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        put_item(CMD_TICK, IDX_W'($urandom), PITCH_W'($urandom), DUR_W'($urandom), 1'b1);
      end else if (pick < 52) begin
        pick_note(p, d);
        if ($urandom_range(0, 3) == 0) begin
          put_item(CMD_WRITE_MUSIC, IDX_W'($urandom), p, d, 1'b1);
        end else begin
          put_item(CMD_WRITE_MUSIC, IDX_W'($urandom_range(0, tune_span - 1)), p, d, 1'b1);
        end
      end else if (pick < 62) begin
        // Short effect: a few notes, usually a terminator, then start it.
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
          pick_note(p, d);
          put_item(CMD_WRITE_SFX, IDX_W'(k), p, d, 1'b1);
        end
        if ($urandom_range(0, 4) != 0) put_item(CMD_WRITE_SFX, IDX_W'(n), '0, '0, 1'b1);
        put_item(CMD_START_SFX, IDX_W'($urandom), PITCH_W'($urandom), DUR_W'($urandom), 1'b1);
      end else if (pick < 67) begin
        put_item(CMD_RESTART_MUS, IDX_W'($urandom), PITCH_W'($urandom), DUR_W'($urandom),
                 1'b1);
      end else if (pick < 71) begin
        put_item(CMD_START_SFX, IDX_W'($urandom), PITCH_W'($urandom), DUR_W'($urandom), 1'b1);
      end else if (pick < 75) begin
        put_item(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), IDX_W'($urandom),
                 PITCH_W'($urandom), DUR_W'($urandom), 1'b0);
      end else if (pick < 79) begin
        put_item(CMD_WRITE_SFX, IDX_W'($urandom_range(EFFECT_DEPTH_DEF, 255)),
                 PITCH_W'($urandom), DUR_W'($urandom), 1'b0);
      end else if (pick < 97 || sweep_done) begin
        repeat ($urandom_range(3, 12)) begin
          put_item(CMD_TICK, IDX_W'($urandom), PITCH_W'($urandom), DUR_W'($urandom), 1'b1);
        end
      end else begin
        // Fill the whole effect table with zero-length notes and play past
        // its end: the position must park there and music take over.
        for (int k = 0; k < EFFECT_DEPTH_DEF; k++) begin
          put_item(CMD_WRITE_SFX, IDX_W'(k), PITCH_W'($urandom_range(1, 65535)), '0, 1'b1);
        end
        put_item(CMD_START_SFX, '0, '0, '0, 1'b1);
        repeat (EFFECT_DEPTH_DEF + 6) put_item(CMD_TICK, '0, '0, '0, 1'b1);
        sweep_done = 1'b1;
      end
    end

    // Drain, let the block settle, then give the verdict.
    in_valid_i <= 1'b0;
    while (awaiting != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && awaiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tsq_pkg.sv
rtl/tsq_table.sv
rtl/tsq_divider.sv
rtl/tone_sequencer_with_sfx_priority.sv
bench/tsq_checker.sv
bench/tb.sv
